@@ hdl/ratiometric_resistance_classifier_macros.svh @@
// Assertion helpers shared by the classifier RTL.
// Every check is clocked on clock and disabled while reset is high.
`ifndef RATIOMETRIC_RESISTANCE_CLASSIFIER_MACROS_SVH
`define RATIOMETRIC_RESISTANCE_CLASSIFIER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/rrc_pkg.sv @@
`default_nettype none

package rrc_pkg;

   // Fixed field widths of the request and result.
   localparam int MEAS_BITS = 16;
   localparam int RES_BITS  = 16;
   localparam int NUM_THR   = 8;
   localparam int CLS_BITS  = 4;
   localparam int CLAMP_BITS = 10;
   localparam int REM_BITS  = 7;

   localparam logic [RES_BITS-1:0]   RES_MAX   = 16'hFFFF;
   localparam logic [CLAMP_BITS-1:0] DIGIT_MAX = 10'd999;

   // Reciprocal constants for the digit split of a value below 1000.
   localparam logic [15:0] HUND_RECIP = 16'd41;   // x / 100 == (x * 41) >> 12
   localparam logic [14:0] TENS_RECIP = 15'd205;  // x / 10  == (x * 205) >> 11

   // Threshold reset values, hundreds of ohms.
   localparam logic [7:0] THR_RESET [NUM_THR] = '{
      8'd55, 8'd67, 8'd82, 8'd97, 8'd113, 8'd128, 8'd138, 8'd144
   };

   // Action codes reported with every result.
   localparam logic [1:0] ACT_CHARGE = 2'd0;
   localparam logic [1:0] ACT_REF    = 2'd1;
   localparam logic [1:0] ACT_SENSOR = 2'd2;

   // Microcode step addresses.
   typedef logic [3:0] step_type;
   localparam step_type ST_WAIT   = 4'd0;
   localparam step_type ST_BRANCH = 4'd1;
   localparam step_type ST_MUL    = 4'd2;
   localparam step_type ST_DIV    = 4'd3;
   localparam step_type ST_SAT    = 4'd4;
   localparam step_type ST_CLASS  = 4'd5;
   localparam step_type ST_DIGH   = 4'd6;
   localparam step_type ST_DIGT   = 4'd7;
   localparam step_type ST_EMITC  = 4'd8;
   localparam step_type ST_MEAS   = 4'd9;
   localparam step_type ST_EMITM  = 4'd10;

   // Datapath operations selected by a control word.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL,
      OP_DIV,
      OP_SAT,
      OP_CLASS,
      OP_DIGH,
      OP_DIGT,
      OP_EMIT_CHARGE,
      OP_MEAS,
      OP_EMIT_MEAS
   } op_type;

   // Jump conditions.
   typedef enum logic [2:0] {
      C_NONE,
      C_NO_ACCEPT,
      C_CHARGED,
      C_DIV_MORE,
      C_OUT_BUSY
   } cond_type;

   // One control word: operation, jump condition and target, end of routine.
   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
      logic     last;
   } ucode_type;

   // The control store.
   function automatic ucode_type ucode_rom(input step_type s);
      ucode_type w;
      case (s)
         ST_WAIT:   w = '{op: OP_LOAD,        cond: C_NO_ACCEPT, target: ST_WAIT,  last: 1'b0};
         ST_BRANCH: w = '{op: OP_NOP,         cond: C_CHARGED,   target: ST_MEAS,  last: 1'b0};
         ST_MUL:    w = '{op: OP_MUL,         cond: C_NONE,      target: ST_WAIT,  last: 1'b0};
         ST_DIV:    w = '{op: OP_DIV,         cond: C_DIV_MORE,  target: ST_DIV,   last: 1'b0};
         ST_SAT:    w = '{op: OP_SAT,         cond: C_NONE,      target: ST_WAIT,  last: 1'b0};
         ST_CLASS:  w = '{op: OP_CLASS,       cond: C_NONE,      target: ST_WAIT,  last: 1'b0};
         ST_DIGH:   w = '{op: OP_DIGH,        cond: C_NONE,      target: ST_WAIT,  last: 1'b0};
         ST_DIGT:   w = '{op: OP_DIGT,        cond: C_NONE,      target: ST_WAIT,  last: 1'b0};
         ST_EMITC:  w = '{op: OP_EMIT_CHARGE, cond: C_OUT_BUSY,  target: ST_EMITC, last: 1'b1};
         ST_MEAS:   w = '{op: OP_MEAS,        cond: C_NONE,      target: ST_WAIT,  last: 1'b0};
         ST_EMITM:  w = '{op: OP_EMIT_MEAS,   cond: C_OUT_BUSY,  target: ST_EMITM, last: 1'b1};
         default:   w = '{op: OP_NOP,         cond: C_NONE,      target: ST_WAIT,  last: 1'b1};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ hdl/ratiometric_resistance_classifier.sv @@
// Charge request: branch, multiply, the restoring divider that retires one quotient bit a cycle,
// saturate, class, hundreds and tens digit steps, then the result is registered. Measure request:
// branch and measure steps, then the result is registered; either waits while the output is busy.
// One request is in work at a time; the next is taken when the sequencer returns to its wait step,
// also while an earlier result still waits in the output register.
// Synchronous active-high reset restores threshold defaults and clears all measurement state.
`default_nettype none

module ratiometric_resistance_classifier
   import rrc_pkg::*;
#(
   parameter int COUNT_BITS   = 16,
   parameter int REF_AVG_LOG2 = 3,
   parameter int SCALE        = 100
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic [MEAS_BITS-1:0] req_meas_count,

   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [1:0]           rsp_action,
   output      logic                 rsp_result_valid,
   output      logic                 rsp_ref_zero,
   output      logic [RES_BITS-1:0]  rsp_resistance,
   output      logic [CLS_BITS-1:0]  rsp_class_index,
   output      logic [7:0]           rsp_bar_mask,
   output      logic [3:0]           rsp_digit_hundreds,
   output      logic [3:0]           rsp_digit_tens,
   output      logic [3:0]           rsp_digit_ones,
   output      logic                 rsp_class_changed,
   output      logic [2:0]           rsp_digits_changed,

   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [4:0]           csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output      logic [31:0]          csr_prdata,
   output      logic                 csr_pready
);

   // Derived widths.
   localparam int CW  = COUNT_BITS;
   localparam int L   = REF_AVG_LOG2;
   localparam int SW  = $clog2(SCALE + 1);
   localparam int NB  = CW + SW;
   localparam int DCW = $clog2(NB + 1);
   localparam int AW  = CW + L;
   localparam int TW  = L + 1;
   localparam int QW  = (NB > RES_BITS) ? NB : RES_BITS + 1;
   localparam logic [TW-1:0] N_REF = TW'(1) << L;

   // Sequencer and measurement state.
   step_type             step_ff, step_in;
   logic                 charged_ff, charged_in;
   logic [TW-1:0]        ref_taken_ff, ref_taken_in;
   logic [AW-1:0]        ref_acc_ff, ref_acc_in;
   logic [CW-1:0]        ref_value_ff, ref_value_in;
   logic [CW-1:0]        sensor_ff, sensor_in;
   logic [CLS_BITS-1:0]  last_class_ff, last_class_in;
   logic [3:0]           last_dig_ff [3];
   logic [3:0]           last_dig_in [3];
   logic [7:0]           thr_ff [NUM_THR];
   logic [7:0]           thr_in [NUM_THR];
   logic                 rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [NB-1:0]        quo_ff, quo_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic [DCW-1:0]       div_cnt_ff, div_cnt_in;
   logic                 rz_ff, rz_in;
   logic [RES_BITS-1:0]  res_ff, res_in;
   logic [CLS_BITS-1:0]  cls_ff, cls_in;
   logic [CLAMP_BITS-1:0] clamp_ff, clamp_in;
   logic [3:0]           hund_ff, hund_in;
   logic [REM_BITS-1:0]  rem2_ff, rem2_in;
   logic [3:0]           tens_ff, tens_in;
   logic [3:0]           ones_ff, ones_in;
   logic [1:0]           act_ff, act_in;

   // Output register.
   logic [1:0]           rsp_action_ff, rsp_action_in;
   logic                 rsp_result_valid_ff, rsp_result_valid_in;
   logic                 rsp_ref_zero_ff, rsp_ref_zero_in;
   logic [RES_BITS-1:0]  rsp_resistance_ff, rsp_resistance_in;
   logic [CLS_BITS-1:0]  rsp_class_index_ff, rsp_class_index_in;
   logic [7:0]           rsp_bar_mask_ff, rsp_bar_mask_in;
   logic [3:0]           rsp_digit_hundreds_ff, rsp_digit_hundreds_in;
   logic [3:0]           rsp_digit_tens_ff, rsp_digit_tens_in;
   logic [3:0]           rsp_digit_ones_ff, rsp_digit_ones_in;
   logic                 rsp_class_changed_ff, rsp_class_changed_in;
   logic [2:0]           rsp_digits_changed_ff, rsp_digits_changed_in;

   // Control word and status.
   ucode_type            uw;
   logic                 accept;
   logic                 out_busy;
   logic                 cond_hit;
   logic                 csr_write;

   // Datapath helpers.
   logic [CW-1:0]        cnt_w;
   logic [NB-1:0]        mul_w;
   logic [CW:0]          trial_w;
   logic [CW:0]          diff_w;
   logic                 ge_w;
   logic [QW-1:0]        quo_ext_w;
   logic [CLS_BITS-1:0]  cls_w;
   logic [7:0]           bar_w;
   logic [15:0]          prod_h_w;
   logic [CLAMP_BITS-1:0] sub_h_w;
   logic [14:0]          prod_t_w;
   logic [REM_BITS-1:0]  sub_t_w;
   logic [AW-1:0]        acc_sum_w;

   // Handshake and control word decode.
   assign uw        = ucode_rom(step_ff);
   assign req_ready = (step_ff == ST_WAIT);
   assign accept    = req_valid && req_ready;
   assign out_busy  = rsp_valid_ff && !rsp_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (uw.cond)
         C_NONE:      cond_hit = 1'b0;
         C_NO_ACCEPT: cond_hit = !req_valid;
         C_CHARGED:   cond_hit = charged_ff;
         C_DIV_MORE:  cond_hit = (div_cnt_ff != DCW'(1));
         C_OUT_BUSY:  cond_hit = out_busy;
         default:     cond_hit = 1'b0;
      endcase
   end

   // Next step: jump, end of routine or fall through.
   always_comb begin
      if (cond_hit) begin
         step_in = uw.target;
      end else if (uw.last) begin
         step_in = ST_WAIT;
      end else begin
         step_in = step_ff + step_type'(1);
      end
   end

   // Shared datapath terms.
   always_comb begin
      cnt_w     = CW'(req_meas_count);
      mul_w     = NB'(sensor_ff) * NB'(SCALE);
      trial_w   = {rem_ff, quo_ff[NB-1]};
      diff_w    = trial_w - {1'b0, ref_value_ff};
      ge_w      = (trial_w >= {1'b0, ref_value_ff});
      quo_ext_w = QW'(quo_ff);
      prod_h_w  = 16'(clamp_ff) * HUND_RECIP;
      sub_h_w   = clamp_ff - (CLAMP_BITS'(prod_h_w[15:12]) * 10'd100);
      prod_t_w  = 15'(rem2_ff) * TENS_RECIP;
      sub_t_w   = rem2_ff - (REM_BITS'(prod_t_w[14:11]) * 7'd10);
      acc_sum_w = ref_acc_ff + AW'(cnt_ff);
   end

   // Class: first threshold not below the resistance; bar lights every lower segment.
   always_comb begin
      cls_w = CLS_BITS'(NUM_THR);
      for (int i = NUM_THR - 1; i >= 0; i--) begin
         if (res_ff <= RES_BITS'(thr_ff[i])) begin
            cls_w = CLS_BITS'(i);
         end
      end
      for (int i = 0; i < 8; i++) begin
         bar_w[i] = (CLS_BITS'(i) < cls_ff);
      end
   end

   // Datapath and state updates driven by the current operation.
   always_comb begin
      charged_in    = charged_ff;
      ref_taken_in  = ref_taken_ff;
      ref_acc_in    = ref_acc_ff;
      ref_value_in  = ref_value_ff;
      sensor_in     = sensor_ff;
      last_class_in = last_class_ff;
      last_dig_in   = last_dig_ff;
      thr_in        = thr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      rz_in      = rz_ff;
      res_in     = res_ff;
      cls_in     = cls_ff;
      clamp_in   = clamp_ff;
      hund_in    = hund_ff;
      rem2_in    = rem2_ff;
      tens_in    = tens_ff;
      ones_in    = ones_ff;
      act_in     = act_ff;

      rsp_action_in         = rsp_action_ff;
      rsp_result_valid_in   = rsp_result_valid_ff;
      rsp_ref_zero_in       = rsp_ref_zero_ff;
      rsp_resistance_in     = rsp_resistance_ff;
      rsp_class_index_in    = rsp_class_index_ff;
      rsp_bar_mask_in       = rsp_bar_mask_ff;
      rsp_digit_hundreds_in = rsp_digit_hundreds_ff;
      rsp_digit_tens_in     = rsp_digit_tens_ff;
      rsp_digit_ones_in     = rsp_digit_ones_ff;
      rsp_class_changed_in  = rsp_class_changed_ff;
      rsp_digits_changed_in = rsp_digits_changed_ff;

      // Threshold writes from the register port.
      if (csr_write) begin
         thr_in[csr_paddr[4:2]] = csr_pwdata[7:0];
      end

      case (uw.op)
         OP_LOAD: begin
            if (accept) begin
               cnt_in = cnt_w;
            end
         end
         OP_MUL: begin
            quo_in     = mul_w;
            rem_in     = '0;
            div_cnt_in = DCW'(NB);
         end
         OP_DIV: begin
            rem_in     = ge_w ? diff_w[CW-1:0] : trial_w[CW-1:0];
            quo_in     = {quo_ff[NB-2:0], ge_w};
            div_cnt_in = div_cnt_ff - DCW'(1);
         end
         OP_SAT: begin
            rz_in = (ref_value_ff == '0);
            if (ref_value_ff == '0 || quo_ext_w > QW'(RES_MAX)) begin
               res_in = RES_MAX;
            end else begin
               res_in = quo_ext_w[RES_BITS-1:0];
            end
         end
         OP_CLASS: begin
            cls_in   = cls_w;
            clamp_in = (res_ff > RES_BITS'(DIGIT_MAX)) ? DIGIT_MAX : res_ff[CLAMP_BITS-1:0];
         end
         OP_DIGH: begin
            hund_in = prod_h_w[15:12];
            rem2_in = sub_h_w[REM_BITS-1:0];
         end
         OP_DIGT: begin
            tens_in = prod_t_w[14:11];
            ones_in = sub_t_w[3:0];
         end
         OP_EMIT_CHARGE: begin
            if (!out_busy) begin
               rsp_valid_in          = 1'b1;
               rsp_action_in         = ACT_CHARGE;
               rsp_result_valid_in   = 1'b1;
               rsp_ref_zero_in       = rz_ff;
               rsp_resistance_in     = res_ff;
               rsp_class_index_in    = cls_ff;
               rsp_bar_mask_in       = bar_w;
               rsp_digit_hundreds_in = hund_ff;
               rsp_digit_tens_in     = tens_ff;
               rsp_digit_ones_in     = ones_ff;
               rsp_class_changed_in  = (cls_ff != last_class_ff);
               rsp_digits_changed_in = {hund_ff != last_dig_ff[2],
                                        tens_ff != last_dig_ff[1],
                                        ones_ff != last_dig_ff[0]};
               last_class_in  = cls_ff;
               last_dig_in[0] = ones_ff;
               last_dig_in[1] = tens_ff;
               last_dig_in[2] = hund_ff;
               charged_in     = 1'b1;
            end
         end
         OP_MEAS: begin
            charged_in = 1'b0;
            if (ref_taken_ff < N_REF) begin
               // Reference averaging; the raw count stands until the last sample.
               ref_acc_in = acc_sum_w;
               if (ref_taken_ff == N_REF - TW'(1)) begin
                  ref_value_in = CW'(acc_sum_w >> L);
               end else begin
                  ref_value_in = cnt_ff;
               end
               ref_taken_in = ref_taken_ff + TW'(1);
               act_in       = ACT_REF;
            end else begin
               sensor_in = cnt_ff;
               act_in    = ACT_SENSOR;
            end
         end
         OP_EMIT_MEAS: begin
            if (!out_busy) begin
               rsp_valid_in          = 1'b1;
               rsp_action_in         = act_ff;
               rsp_result_valid_in   = 1'b0;
               rsp_ref_zero_in       = 1'b0;
               rsp_resistance_in     = '0;
               rsp_class_index_in    = '0;
               rsp_bar_mask_in       = '0;
               rsp_digit_hundreds_in = '0;
               rsp_digit_tens_in     = '0;
               rsp_digit_ones_in     = '0;
               rsp_class_changed_in  = 1'b0;
               rsp_digits_changed_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control and measurement state, cleared by reset; thresholds return to their defaults.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= ST_WAIT;
         charged_ff    <= 1'b0;
         ref_taken_ff  <= '0;
         ref_acc_ff    <= '0;
         ref_value_ff  <= '0;
         sensor_ff     <= '0;
         last_class_ff <= '0;
         last_dig_ff   <= '{default: 4'd0};
         thr_ff        <= THR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         step_ff       <= step_in;
         charged_ff    <= charged_in;
         ref_taken_ff  <= ref_taken_in;
         ref_acc_ff    <= ref_acc_in;
         ref_value_ff  <= ref_value_in;
         sensor_ff     <= sensor_in;
         last_class_ff <= last_class_in;
         last_dig_ff   <= last_dig_in;
         thr_ff        <= thr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath and output payload registers.
   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      rz_ff      <= rz_in;
      res_ff     <= res_in;
      cls_ff     <= cls_in;
      clamp_ff   <= clamp_in;
      hund_ff    <= hund_in;
      rem2_ff    <= rem2_in;
      tens_ff    <= tens_in;
      ones_ff    <= ones_in;
      act_ff     <= act_in;

      rsp_action_ff         <= rsp_action_in;
      rsp_result_valid_ff   <= rsp_result_valid_in;
      rsp_ref_zero_ff       <= rsp_ref_zero_in;
      rsp_resistance_ff     <= rsp_resistance_in;
      rsp_class_index_ff    <= rsp_class_index_in;
      rsp_bar_mask_ff       <= rsp_bar_mask_in;
      rsp_digit_hundreds_ff <= rsp_digit_hundreds_in;
      rsp_digit_tens_ff     <= rsp_digit_tens_in;
      rsp_digit_ones_ff     <= rsp_digit_ones_in;
      rsp_class_changed_ff  <= rsp_class_changed_in;
      rsp_digits_changed_ff <= rsp_digits_changed_in;
   end

   // Port drive.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = rsp_action_ff;
   assign rsp_result_valid   = rsp_result_valid_ff;
   assign rsp_ref_zero       = rsp_ref_zero_ff;
   assign rsp_resistance     = rsp_resistance_ff;
   assign rsp_class_index    = rsp_class_index_ff;
   assign rsp_bar_mask       = rsp_bar_mask_ff;
   assign rsp_digit_hundreds = rsp_digit_hundreds_ff;
   assign rsp_digit_tens     = rsp_digit_tens_ff;
   assign rsp_digit_ones     = rsp_digit_ones_ff;
   assign rsp_class_changed  = rsp_class_changed_ff;
   assign rsp_digits_changed = rsp_digits_changed_ff;
   assign csr_prdata         = 32'(thr_ff[csr_paddr[4:2]]);
   assign csr_pready         = 1'b1;

   // Checks on the sequencer and datapath.
`include "ratiometric_resistance_classifier_macros.svh"

   `RRC_ASSERT_NEXT(a_accept_branch, accept, step_ff == ST_BRANCH, "accepted request did not reach the branch step")
   `RRC_ASSERT_SAME(a_div_count, step_ff == ST_DIV, div_cnt_ff != '0, "divider step entered with no bits left")
   `RRC_ASSERT_SAME(a_ref_bound, 1'b1, ref_taken_ff <= N_REF, "reference sample count overran")
   `RRC_ASSERT_SAME(a_digits, rsp_valid_ff && rsp_result_valid_ff, (rsp_digit_hundreds_ff <= 4'd9) && (rsp_digit_tens_ff <= 4'd9) && (rsp_digit_ones_ff <= 4'd9), "digit out of decimal range")
   `RRC_ASSERT_SAME(a_meas_clean, rsp_valid_ff && !rsp_result_valid_ff, (rsp_action_ff != ACT_CHARGE) && (rsp_class_index_ff == '0) && (rsp_resistance_ff == '0), "measure result carries class data")

endmodule

`default_nettype wire
